// ===== rtl/core/scv_pkg.sv =====
package scv_pkg;

    // Table depth and derived widths
    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int CFG_W       = 11;
    localparam int EXT_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int SURV_W  = 17;
    localparam int HAZ_W   = 32;
    localparam int ALPHA_W = 17;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;

    // Arithmetic unit
    localparam int Q_W        = 64;
    localparam int K_W        = 6;
    localparam int DIV_W      = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int TAYLOR_MAX = 40;
    localparam int SQUARINGS  = 8;

    localparam logic [Q_W-1:0]    Q62_ONE  = Q_W'(1) << 62;
    localparam logic [SURV_W-1:0] SURV_ONE = SURV_W'(65536);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_APPEND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SURVIVAL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUANTILE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_ANSWER = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR     = 2'd2;

    typedef struct packed {
        logic [HAZ_W-1:0] hazard;
        logic             censored;
        logic [CNT_W-1:0] denom;
    } t_arith_req;

    typedef struct packed {
        logic [HAZ_W-1:0]  hazard;
        logic [SURV_W-1:0] survival;
    } t_arith_rsp;

endpackage

// ===== rtl/core/scv_ram.sv =====
module scv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/scv_arith.sv =====
module scv_arith import scv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_arith_req i_req,
    output logic       o_done,
    output t_arith_rsp o_rsp
);

    localparam logic [3:0] A_IDLE   = 4'd0;
    localparam logic [3:0] A_HDIV   = 4'd1;
    localparam logic [3:0] A_HADD   = 4'd2;
    localparam logic [3:0] A_TMUL   = 4'd3;
    localparam logic [3:0] A_TDIVLD = 4'd4;
    localparam logic [3:0] A_TDIV   = 4'd5;
    localparam logic [3:0] A_TACC   = 4'd6;
    localparam logic [3:0] A_VSET   = 4'd7;
    localparam logic [3:0] A_SQ     = 4'd8;
    localparam logic [3:0] A_SQW    = 4'd9;
    localparam logic [3:0] A_DONE   = 4'd10;

    logic [3:0]       r_state;
    logic [HAZ_W-1:0] r_hazard;
    logic             r_cens;
    logic [Q_W-1:0]   r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvsr;
    logic [6:0]       r_dcnt;
    logic [Q_W-1:0]   r_pp;
    logic [1:0]       r_psh;
    logic [2*Q_W-1:0] r_acc;
    logic [2:0]       r_mcnt;
    logic [Q_W-1:0]   r_term;
    logic [Q_W-1:0]   r_pos;
    logic [Q_W-1:0]   r_neg;
    logic [K_W-1:0]   r_k;
    logic [Q_W-1:0]   r_v;
    logic [2:0]       r_sq;

    logic [Q_W-1:0]   y_q62;
    logic [DIV_W:0]   d_trial;
    logic             d_fit;
    logic [DIV_W:0]   d_diff;
    logic [DIV_W-1:0] n_rem;
    logic [Q_W-1:0]   m_a;
    logic [Q_W-1:0]   m_b;
    logic [31:0]      a_half;
    logic [31:0]      b_half;
    logic [Q_W-1:0]   n_pp;
    logic [1:0]       n_psh;
    logic [2*Q_W-1:0] pp_shifted;
    logic [2*Q_W-1:0] acc_sum;
    logic             mul_last;
    logic [HAZ_W:0]   haz_sum;
    logic [Q_W-1:0]   v_round;

    assign y_q62 = {2'b00, r_hazard, 30'd0};

    // One restoring divide step
    always_comb begin
        d_trial = {r_rem, r_quo[Q_W-1]};
        d_fit   = d_trial >= {1'b0, r_dvsr};
        d_diff  = d_trial - {1'b0, r_dvsr};
        n_rem   = d_fit ? d_diff[DIV_W-1:0] : d_trial[DIV_W-1:0];
    end

    // One 32x32 partial product a cycle; accumulate the previous one
    always_comb begin
        m_a    = (r_state == A_SQ) ? r_v : r_term;
        m_b    = (r_state == A_SQ) ? r_v : y_q62;
        a_half = r_mcnt[1] ? m_a[63:32] : m_a[31:0];
        b_half = r_mcnt[0] ? m_b[63:32] : m_b[31:0];
        n_pp   = Q_W'(a_half) * Q_W'(b_half);
        n_psh  = 2'(r_mcnt[1]) + 2'(r_mcnt[0]);
        case (r_psh)
            2'd0:    pp_shifted = {64'd0, r_pp};
            2'd1:    pp_shifted = {32'd0, r_pp, 32'd0};
            default: pp_shifted = {r_pp, 64'd0};
        endcase
        acc_sum  = r_acc + pp_shifted;
        mul_last = r_mcnt == 3'd4;
    end

    assign haz_sum = {1'b0, r_hazard} + {1'b0, r_quo[HAZ_W-1:0]};
    assign v_round = r_v + (Q_W'(1) << 45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            unique case (r_state) inside
                A_IDLE: begin
                    if (i_start) begin
                        r_hazard <= i_req.hazard;
                        r_cens   <= i_req.censored;
                        r_quo    <= Q_W'(1) << 24;
                        r_rem    <= '0;
                        r_dvsr   <= DIV_W'(i_req.denom);
                        r_dcnt   <= '0;
                        r_state  <= i_req.censored ? A_HADD : A_HDIV;
                    end
                end
                A_HDIV: begin
                    r_quo  <= {r_quo[Q_W-2:0], d_fit};
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd63) begin
                        r_state <= A_HADD;
                    end
                end
                A_HADD: begin
                    if (!r_cens) begin
                        r_hazard <= haz_sum[HAZ_W] ? '1 : haz_sum[HAZ_W-1:0];
                    end
                    r_term  <= Q62_ONE;
                    r_pos   <= Q62_ONE;
                    r_neg   <= '0;
                    r_k     <= K_W'(1);
                    r_mcnt  <= '0;
                    r_acc   <= '0;
                    r_state <= A_TMUL;
                end
                A_TMUL, A_SQ: begin
                    if (!mul_last) begin
                        r_pp  <= n_pp;
                        r_psh <= n_psh;
                    end
                    if (r_mcnt != 3'd0) begin
                        r_acc <= acc_sum;
                    end
                    r_mcnt <= r_mcnt + 3'd1;
                    if (mul_last) begin
                        r_state <= (r_state == A_SQ) ? A_SQW : A_TDIVLD;
                    end
                end
                A_TDIVLD: begin
                    r_quo   <= r_acc[125:62];
                    r_rem   <= '0;
                    r_dvsr  <= DIV_W'(r_k);
                    r_dcnt  <= '0;
                    r_state <= A_TDIV;
                end
                A_TDIV: begin
                    r_quo  <= {r_quo[Q_W-2:0], d_fit};
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd63) begin
                        r_state <= A_TACC;
                    end
                end
                A_TACC: begin
                    r_term <= r_quo;
                    if (r_k[0]) begin
                        r_neg <= r_neg + r_quo;
                    end else begin
                        r_pos <= r_pos + r_quo;
                    end
                    if (r_k == K_W'(TAYLOR_MAX) || r_quo == '0) begin
                        r_state <= A_VSET;
                    end else begin
                        r_k     <= r_k + K_W'(1);
                        r_mcnt  <= '0;
                        r_acc   <= '0;
                        r_state <= A_TMUL;
                    end
                end
                A_VSET: begin
                    r_v     <= r_pos - r_neg;
                    r_sq    <= '0;
                    r_mcnt  <= '0;
                    r_acc   <= '0;
                    r_state <= A_SQ;
                end
                A_SQW: begin
                    r_v  <= r_acc[125:62];
                    r_sq <= r_sq + 3'd1;
                    if (r_sq == 3'(SQUARINGS - 1)) begin
                        r_state <= A_DONE;
                    end else begin
                        r_mcnt  <= '0;
                        r_acc   <= '0;
                        r_state <= A_SQ;
                    end
                end
                A_DONE: begin
                    r_state <= A_IDLE;
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_done         = r_state == A_DONE;
    assign o_rsp.hazard   = r_hazard;
    assign o_rsp.survival = v_round[62:46];

endmodule

// ===== rtl/core/survival_curve_estimator.sv =====
// Nelson-Aalen survival curve. Load sample_count observations with append
// items in ascending time order, then ask survival or quantile queries; a
// clear item empties the table. Every item gives exactly one result on
// o_valid, one cycle wide, and the receiver cannot stall it: capture it when
// it shows. busy is high while an item is in work. Clear, rejected items and
// quantiles with alpha at 0 or at 1.0 and above answer in the cycle after
// acceptance. An append runs through the arithmetic unit: a 64-step
// restoring divide for the hazard step (skipped for a censored observation),
// then for each Taylor term a 64x64 multiply (four 32x32 partial products,
// then the last add) and a 64-step divide by the term index (1 to 40 terms),
// then eight squarings. Queries are bound by the single read port of the
// table: the last entry is read and checked first, then each scanned entry
// in turn is read and checked, from entry zero upwards.
module survival_curve_estimator import scv_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [TIME_W-1:0]  i_time_value,
    input  logic               i_censored_flag,
    input  logic [ALPHA_W-1:0] i_alpha,
    output logic               o_valid,
    output logic [SURV_W-1:0]  o_survival,
    output logic [TIME_W-1:0]  o_time_result,
    output logic [STAT_W-1:0]  o_status
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_APPEND   = 3'd1;
    localparam logic [2:0] S_RD_LAST  = 3'd2;
    localparam logic [2:0] S_CHK_LAST = 3'd3;
    localparam logic [2:0] S_SCAN_RD  = 3'd4;
    localparam logic [2:0] S_SCAN_CHK = 3'd5;

    logic [2:0]         r_state;
    logic [CFG_W-1:0]   r_sample_count;
    logic [CNT_W-1:0]   r_loaded;
    logic [HAZ_W-1:0]   r_hazard;
    logic               r_last_cens;
    logic               r_quant;
    logic [TIME_W-1:0]  r_time;
    logic               r_cens;
    logic [ALPHA_W-1:0] r_alpha;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  r_last_idx;
    logic [SURV_W-1:0]  r_last_surv;
    logic [SURV_W-1:0]  r_prev_surv;
    logic               r_after;
    logic               r_out_valid;
    logic [SURV_W-1:0]  r_out_surv;
    logic [TIME_W-1:0]  r_out_time;
    logic [STAT_W-1:0]  r_out_status;

    logic [EXT_W-1:0]   sc_ext;
    logic [CNT_W-1:0]   n_eff;
    logic               accept;
    logic               full;
    logic               arith_start;
    logic               arith_done;
    t_arith_req         arith_req;
    t_arith_rsp         arith_rsp;
    logic [ADDR_W-1:0]  raddr;
    logic [TIME_W-1:0]  rd_time;
    logic [SURV_W-1:0]  rd_surv;
    logic               at_last;

    // Effective sample count: zero counts as one, clamp to the table depth
    always_comb begin
        sc_ext = EXT_W'(r_sample_count);
        if (sc_ext == '0) begin
            n_eff = CNT_W'(1);
        end else if (sc_ext > EXT_W'(MAX_SAMPLES)) begin
            n_eff = CNT_W'(MAX_SAMPLES);
        end else begin
            n_eff = sc_ext[CNT_W-1:0];
        end
    end

    assign busy        = r_state != S_IDLE;
    assign accept      = start && !busy;
    assign full        = r_loaded >= n_eff;
    assign arith_start = accept && (i_req_type == REQ_APPEND) && !full;

    assign arith_req.hazard   = r_hazard;
    assign arith_req.censored = i_censored_flag;
    assign arith_req.denom    = n_eff - r_loaded;

    scv_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (arith_start),
        .i_req   (arith_req),
        .o_done  (arith_done),
        .o_rsp   (arith_rsp)
    );

    // Fetch the last entry first, then scan upwards from entry zero
    assign raddr   = (r_state == S_RD_LAST) ? r_last_idx : r_idx;
    assign at_last = r_idx == r_last_idx;

    scv_ram #(.WIDTH(TIME_W), .DEPTH(MAX_SAMPLES)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (arith_done),
        .i_waddr (r_loaded[ADDR_W-1:0]),
        .i_wdata (r_time),
        .i_raddr (raddr),
        .o_rdata (rd_time)
    );

    scv_ram #(.WIDTH(SURV_W), .DEPTH(MAX_SAMPLES)) u_surv_ram (
        .i_clk   (i_clk),
        .i_we    (arith_done),
        .i_waddr (r_loaded[ADDR_W-1:0]),
        .i_wdata (arith_rsp.survival),
        .i_raddr (raddr),
        .o_rdata (rd_surv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_count <= CFG_W'(1);
            r_loaded       <= '0;
            r_hazard       <= '0;
            r_last_cens    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_sample_count <= i_cfg_wdata;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_time     <= i_time_value;
                        r_cens     <= i_censored_flag;
                        r_alpha    <= i_alpha;
                        r_quant    <= i_req_type == REQ_QUANTILE;
                        r_idx      <= '0;
                        r_last_idx <= ADDR_W'(r_loaded - CNT_W'(1));
                        r_out_surv <= '0;
                        r_out_time <= '0;
                        unique case (i_req_type) inside
                            REQ_APPEND: begin
                                if (full) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_ERROR;
                                end else begin
                                    r_state <= S_APPEND;
                                end
                            end
                            REQ_CLEAR: begin
                                r_loaded     <= '0;
                                r_hazard     <= '0;
                                r_last_cens  <= 1'b0;
                                r_out_valid  <= 1'b1;
                                r_out_status <= ST_OK;
                            end
                            REQ_SURVIVAL, REQ_QUANTILE: begin
                                if (r_loaded < n_eff) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_ERROR;
                                end else if (i_req_type == REQ_QUANTILE &&
                                             (i_alpha == '0 || i_alpha[ALPHA_W-1])) begin
                                    r_out_valid  <= 1'b1;
                                    r_out_status <= ST_NO_ANSWER;
                                end else begin
                                    r_state <= S_RD_LAST;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_APPEND: begin
                    // Commit the entry in the cycle the arithmetic finishes
                    if (arith_done) begin
                        r_loaded     <= r_loaded + CNT_W'(1);
                        r_hazard     <= arith_rsp.hazard;
                        r_last_cens  <= r_cens;
                        r_out_valid  <= 1'b1;
                        r_out_surv   <= arith_rsp.survival;
                        r_out_time   <= '0;
                        r_out_status <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                S_RD_LAST: begin
                    r_state <= S_CHK_LAST;
                end
                S_CHK_LAST: begin
                    r_last_surv <= rd_surv;
                    r_after     <= r_time > rd_time;
                    if (r_quant && r_alpha < rd_surv) begin
                        // Curve never falls to alpha: the tail decides
                        r_out_valid  <= 1'b1;
                        r_out_surv   <= '0;
                        r_out_time   <= r_last_cens ? '0 : rd_time;
                        r_out_status <= r_last_cens ? ST_NO_ANSWER : ST_OK;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    r_out_surv   <= '0;
                    r_out_time   <= '0;
                    r_out_status <= ST_OK;
                    if (r_quant) begin
                        if (at_last || rd_surv <= r_alpha) begin
                            r_out_valid <= 1'b1;
                            r_out_time  <= rd_time;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + ADDR_W'(1);
                            r_state <= S_SCAN_RD;
                        end
                    end else if (r_idx == '0 && r_time < rd_time) begin
                        // Before the first time the curve is still one
                        r_out_valid <= 1'b1;
                        r_out_surv  <= SURV_ONE;
                        r_state     <= S_IDLE;
                    end else if (r_after) begin
                        // Past the last time: hold the last value only if censored
                        r_out_valid <= 1'b1;
                        r_out_surv  <= r_last_cens ? r_last_surv : '0;
                        r_state     <= S_IDLE;
                    end else if (at_last || r_time <= rd_time) begin
                        r_out_valid <= 1'b1;
                        r_out_surv  <= (rd_time == r_time || r_idx == '0) ?
                                       rd_surv : r_prev_surv;
                        r_state     <= S_IDLE;
                    end else begin
                        r_prev_surv <= rd_surv;
                        r_idx       <= r_idx + ADDR_W'(1);
                        r_state     <= S_SCAN_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_survival    = r_out_surv;
    assign o_time_result = r_out_time;
    assign o_status      = r_out_status;

endmodule

// ===== rtl/core/scv_checker.sv =====
module scv_checker import scv_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [SURV_W-1:0]  o_survival,
    input logic [TIME_W-1:0]  o_time_result,
    input logic [STAT_W-1:0]  o_status
);

    // A result closes its item, so the block is free when it shows
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // An accepted item either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted item dropped");

    // No result without an item in work
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(busy)) |-> $past(start))
        else $error("result with no item");

    // Errors and no-answer results carry zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_ERROR || o_status == ST_NO_ANSWER)) |->
        (o_survival == '0 && o_time_result == '0))
        else $error("payload on error result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NO_ANSWER ||
                     o_status == ST_ERROR))
        else $error("bad status code");

endmodule

bind survival_curve_estimator scv_checker u_scv_checker (.*);
